### sv/fmsp_pkg.sv
package fmsp_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_SEVEN = 8'h37;
   localparam logic [7:0] CHAR_A     = 8'h61;
   localparam logic [7:0] CHAR_U     = 8'h75;
   localparam logic [7:0] CHAR_G     = 8'h67;
   localparam logic [7:0] CHAR_O     = 8'h6f;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_EQUAL = 8'h3d;
   localparam logic [7:0] CHAR_R     = 8'h72;
   localparam logic [7:0] CHAR_W     = 8'h77;
   localparam logic [7:0] CHAR_X     = 8'h78;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_FORMAT   = 3'd1;
   localparam logic [2:0] ERR_LENGTH   = 3'd2;
   localparam logic [2:0] ERR_OPERATOR = 3'd3;
   localparam logic [2:0] ERR_PERM     = 3'd4;
   localparam logic [2:0] ERR_OCTAL    = 3'd5;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_SET = 2'd2;

   localparam logic [1:0] CLS_OTHER = 2'd0;
   localparam logic [1:0] CLS_GROUP = 2'd1;
   localparam logic [1:0] CLS_USER  = 2'd2;
   localparam logic [1:0] CLS_ALL   = 2'd3;

   localparam logic [2:0] PERM_R = 3'b100;
   localparam logic [2:0] PERM_W = 3'b010;
   localparam logic [2:0] PERM_X = 3'b001;

   localparam logic [2:0] POS_MAX = 3'd7;
   localparam logic [2:0] POS_OCTAL_LAST = 3'd3;
   localparam logic [2:0] LEN_OCTAL = 3'd4;
   localparam logic [3:0] LEN_MIN = 4'd3;
   localparam logic [3:0] LEN_MAX = 4'd5;

   typedef struct packed {
      logic [7:0]  char_in;
      logic        is_last;
      logic [15:0] current_mode;
   } item_type;

   typedef struct packed {
      logic [2:0] position;
      logic       octal_form;
      logic       implied_all;
      logic [1:0] class_select;
      logic [1:0] operator_kind;
      logic [2:0] perm_bits;
      logic [8:0] octal_value;
      logic [2:0] sticky_error;
   } state_type;

   typedef struct packed {
      logic [15:0] new_mode;
      logic [2:0]  error_code;
   } result_type;

endpackage

### sv/file_mode_string_parser.sv
// Permission-mode string parser. Send one character per transfer on the req_
// channel, first character first, with req_is_last on the final one; the
// file's current mode is read only with that final character. The rsp_
// channel gives one transfer per string: the new mode and an error code
// (0 ok, 1 format, 2 length, 3 operator, 4 permission, 5 octal), with the
// mode zero on any error. Symbolic strings are class (u g o a, or omitted
// before the operator), operator (+ - =), then r w x letters; octal strings
// are 0 and three octal digits. The block takes one character every cycle
// unless the input side stalls. A result passes through the input register,
// where its last character is held while the parse logic works on it, and
// then the result register, which is loaded when that character is taken.
// The input side stalls only when a final character waits for a result
// register that is still full and not being taken.
module file_mode_string_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   input  logic        req_is_last,
   input  logic [15:0] req_current_mode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_new_mode,
   output logic [2:0]  rsp_error_code
);
   import fmsp_pkg::*;

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       take;
   logic       load;
   result_type result;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rsp_new_mode_ff;
   logic [2:0]  rsp_error_code_ff;

   assign req_item.char_in      = req_char_in;
   assign req_item.is_last      = req_is_last;
   assign req_item.current_mode = req_current_mode;

   fmsp_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .take       (take)
   );

   assign take = item_valid && (!item.is_last || !rsp_valid_ff || rsp_ready);
   assign load = take && item.is_last;

   fmsp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (take),
      .item   (item),
      .result (result)
   );

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_new_mode_ff   <= result.new_mode;
         rsp_error_code_ff <= result.error_code;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_mode   = rsp_new_mode_ff;
   assign rsp_error_code = rsp_error_code_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!rsp_valid_ff || rsp_ready)) else $error("result overwritten");

   a_result_follows_last: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff) else $error("result missing after last");

   a_error_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_error_code_ff <= ERR_OCTAL))
      else $error("error code out of range");

endmodule

### sv/fmsp_input_reg.sv
module fmsp_input_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fmsp_pkg::item_type req_item,
   output logic              item_valid,
   output fmsp_pkg::item_type item,
   input  logic              take
);
   import fmsp_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     load;

   assign req_ready  = !valid_ff || take;
   assign load       = req_valid && req_ready;
   assign valid_in   = load || (valid_ff && !take);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   a_take_needs_item: assert property (@(posedge clock) disable iff (reset)
      take |-> valid_ff) else $error("take without a held item");

   a_refill_on_take: assert property (@(posedge clock) disable iff (reset)
      (take && !req_valid) |=> !valid_ff) else $error("item held after drain");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !take) |=> (valid_ff && $stable(item_ff)))
      else $error("held item lost on stall");

endmodule

### sv/fmsp_core.sv
module fmsp_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  fmsp_pkg::item_type   item,
   output fmsp_pkg::result_type result
);
   import fmsp_pkg::*;

   state_type   st_ff;
   state_type   st_in;
   logic [7:0]  c;
   logic [3:0]  len;
   logic [8:0]  mask;
   logic [15:0] sym_mode;
   logic [15:0] mode;
   logic [2:0]  err;
   logic        is_op;
   logic [1:0]  op_code;

   assign c = item.char_in;

   always_comb begin
      is_op   = 1'b1;
      op_code = OP_ADD;
      priority if (c == CHAR_PLUS) begin
         op_code = OP_ADD;
      end else if (c == CHAR_MINUS) begin
         op_code = OP_SUB;
      end else if (c == CHAR_EQUAL) begin
         op_code = OP_SET;
      end else begin
         is_op = 1'b0;
      end
   end

   always_comb begin
      st_in = st_ff;
      if (st_ff.position == 3'd0) begin
         priority if (c == CHAR_ZERO) begin
            st_in.octal_form = 1'b1;
         end else if (c == CHAR_A) begin
            st_in.class_select = CLS_ALL;
         end else if (c == CHAR_U) begin
            st_in.class_select = CLS_USER;
         end else if (c == CHAR_G) begin
            st_in.class_select = CLS_GROUP;
         end else if (c == CHAR_O) begin
            st_in.class_select = CLS_OTHER;
         end else if (is_op) begin
            st_in.operator_kind = op_code;
            st_in.implied_all   = 1'b1;
            st_in.class_select  = CLS_ALL;
         end else begin
            st_in.sticky_error = ERR_FORMAT;
         end
      end else if (st_ff.sticky_error != ERR_FORMAT) begin
         if (st_ff.octal_form) begin
            if (st_ff.position <= POS_OCTAL_LAST) begin
               if (c < CHAR_ZERO || c > CHAR_SEVEN) begin
                  if (st_ff.sticky_error == ERR_NONE) begin
                     st_in.sticky_error = ERR_OCTAL;
                  end
               end else begin
                  st_in.octal_value = {st_ff.octal_value[5:0], c[2:0]};
               end
            end
         end else if (st_ff.position == 3'd1 && !st_ff.implied_all) begin
            if (is_op) begin
               st_in.operator_kind = op_code;
            end else if (st_ff.sticky_error == ERR_NONE) begin
               st_in.sticky_error = ERR_OPERATOR;
            end
         end else if (c == CHAR_R) begin
            st_in.perm_bits = st_ff.perm_bits | PERM_R;
         end else if (c == CHAR_W) begin
            st_in.perm_bits = st_ff.perm_bits | PERM_W;
         end else if (c == CHAR_X) begin
            st_in.perm_bits = st_ff.perm_bits | PERM_X;
         end else if (st_ff.sticky_error == ERR_NONE) begin
            st_in.sticky_error = ERR_PERM;
         end
      end
      if (st_ff.position < POS_MAX) begin
         st_in.position = st_ff.position + 3'd1;
      end
   end

   always_comb begin
      unique case (st_in.class_select)
         CLS_OTHER: mask = {6'd0, st_in.perm_bits};
         CLS_GROUP: mask = {3'd0, st_in.perm_bits, 3'd0};
         CLS_USER:  mask = {st_in.perm_bits, 6'd0};
         default:   mask = {3{st_in.perm_bits}};
      endcase
   end

   always_comb begin
      sym_mode = 16'd0;
      unique case (st_in.operator_kind)
         OP_ADD: sym_mode = item.current_mode | {7'd0, mask};
         OP_SUB: sym_mode = item.current_mode & ~{7'd0, mask};
         default: begin
            for (int k = 0; k < 3; k++) begin
               sym_mode[3*k +: 3] = (mask[3*k +: 3] != 3'd0) ?
                                    mask[3*k +: 3] : item.current_mode[3*k +: 3];
            end
         end
      endcase
   end

   assign len = {1'b0, st_in.position} + {3'd0, st_in.implied_all};

   always_comb begin
      mode = 16'd0;
      err  = ERR_NONE;
      if (st_in.sticky_error == ERR_FORMAT) begin
         err = ERR_FORMAT;
      end else if (st_in.octal_form) begin
         if (st_in.position != LEN_OCTAL || st_in.sticky_error != ERR_NONE) begin
            err = ERR_OCTAL;
         end else begin
            mode = {7'd0, st_in.octal_value};
         end
      end else if (len < LEN_MIN || len > LEN_MAX) begin
         err = ERR_LENGTH;
      end else if (st_in.sticky_error != ERR_NONE) begin
         err = st_in.sticky_error;
      end else begin
         mode = sym_mode;
      end
   end

   assign result.new_mode   = mode;
   assign result.error_code = err;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (fire) begin
         st_ff <= item.is_last ? '0 : st_in;
      end
   end

   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      (fire && item.is_last) |=> (st_ff == '0)) else $error("state kept after last");

   a_position_advance: assert property (@(posedge clock) disable iff (reset)
      (fire && !item.is_last && st_ff.position < POS_MAX)
      |=> (st_ff.position == $past(st_ff.position) + 3'd1))
      else $error("position did not advance");

   a_error_range: assert property (@(posedge clock) disable iff (reset)
      st_ff.sticky_error <= ERR_OCTAL) else $error("sticky error out of range");

   a_error_zero_mode: assert property (@(posedge clock) disable iff (reset)
      (fire && item.is_last && result.error_code != ERR_NONE) |-> (result.new_mode == 16'd0))
      else $error("mode not cleared on error");

endmodule
